/* rtl/ncv_pkg.sv */
package ncv_pkg;

    localparam int MAX_KERNEL = 5;
    localparam int MAX_WIDTH  = 1024;
    localparam int CHANNELS   = 3;

    localparam int PIX_W    = 8;
    localparam int COEF_W   = 16;
    localparam int NORM_W   = 21;
    localparam int ROW_W    = 16;
    localparam int WCFG_W   = 11;
    localparam int KCFG_W   = 3;
    localparam int CIDX_W   = 5;
    localparam int CFGA_W   = 2;
    localparam int CFGD_W   = 16;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int WEFF_W   = COL_W + 1;
    localparam int NTAPS    = MAX_KERNEL * MAX_KERNEL;
    localparam int TAP_W    = $clog2(NTAPS + 1);
    localparam int KS_W     = $clog2(MAX_KERNEL + 1);
    localparam int PROD_W   = PIX_W + COEF_W;
    localparam int ACC_W    = PROD_W + $clog2(NTAPS);
    localparam int DCNT_W   = $clog2(ACC_W);

    // input op codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // configuration register indexes
    localparam logic [CFGA_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFGA_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFGA_W-1:0] CFG_KERNEL = 2'd2;

    typedef logic [PIX_W-1:0] sample_t;
    typedef sample_t [CHANNELS-1:0] pixel_t;
    typedef pixel_t [MAX_KERNEL-1:0][MAX_KERNEL-1:0] window_t;
    typedef pixel_t [MAX_KERNEL-2:0] line_word_t;

    typedef struct packed {
        logic                is_coef;
        logic [CIDX_W-1:0]   coef_index;
        logic [COEF_W-1:0]   coef_value;
        window_t             win;
        logic                eof;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SHIFT,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_NORM,
        B_MUL,
        B_DIV,
        B_OUT
    } back_state_t;

endpackage

/* rtl/normalized_2d_convolution_unit.sv */
// operation: an accepted pixel passes through the window shift and queue write in the
//   front end; the back end then dispatches it, runs the multiply-accumulate over
//   the k*k taps and the bit-serial divide, and loads the output; a zero norm skips
//   straight to the output load. the front end keeps accepting pixels while the back
//   end works, until the two-entry queue is full; pixels outside the valid window are
//   not queued; a coefficient load or kernel size write adds a norm sweep. reset:
//   asynchronous, active low; counters, coefficients and norm clear to zero, width/height/kernel to 1024/1024/3
module normalized_2d_convolution_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    // input words
    input  logic                         push,
    output logic                         full,
    input  logic                         op,
    input  logic [ncv_pkg::CIDX_W-1:0]   coef_index,
    input  logic [ncv_pkg::COEF_W-1:0]   coef_value,
    input  logic [ncv_pkg::PIX_W-1:0]    pixel_ch0,
    input  logic [ncv_pkg::PIX_W-1:0]    pixel_ch1,
    input  logic [ncv_pkg::PIX_W-1:0]    pixel_ch2,
    // result words
    output logic                         empty,
    input  logic                         pop,
    output logic [ncv_pkg::PIX_W-1:0]    out_ch0,
    output logic [ncv_pkg::PIX_W-1:0]    out_ch1,
    output logic [ncv_pkg::PIX_W-1:0]    out_ch2,
    output logic                         end_of_frame,
    output logic                         divide_error,
    // configuration words
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ncv_pkg::CFGA_W-1:0]   cfg_index,
    input  logic [ncv_pkg::CFGD_W-1:0]   cfg_data
);

    // configuration registers
    logic [ncv_pkg::WCFG_W-1:0] width_reg;
    logic [ncv_pkg::ROW_W-1:0]  height_reg;
    logic [ncv_pkg::KCFG_W-1:0] kernel_reg;
    logic                       cfg_wr;
    logic                       norm_start;

    // clamped working values
    logic [ncv_pkg::KS_W-1:0]   k_eff;
    logic [ncv_pkg::WEFF_W-1:0] w_eff;
    logic [ncv_pkg::ROW_W-1:0]  h_eff;

    ncv_pkg::pixel_t            in_pix;
    ncv_pkg::pixel_t            res_pix;

    // front to back queue
    logic                       q_push, q_pop;
    ncv_pkg::entry_t            q_din, q_dout;
    ncv_pkg::fifo_stat_t        q_stat;

    always_comb
    begin
        cfg_ready  = 1'b1;
        cfg_wr     = cfg_valid && cfg_ready;
        norm_start = cfg_wr && (cfg_index == ncv_pkg::CFG_KERNEL);

        // out-of-range register values act as the nearest legal one
        if (kernel_reg == '0)
        begin
            k_eff = ncv_pkg::KS_W'(1);
        end
        else if (ncv_pkg::KS_W'(kernel_reg) > ncv_pkg::KS_W'(ncv_pkg::MAX_KERNEL))
        begin
            k_eff = ncv_pkg::KS_W'(ncv_pkg::MAX_KERNEL);
        end
        else
        begin
            k_eff = ncv_pkg::KS_W'(kernel_reg);
        end
        if (width_reg == '0)
        begin
            w_eff = ncv_pkg::WEFF_W'(1);
        end
        else if (ncv_pkg::WEFF_W'(width_reg) > ncv_pkg::WEFF_W'(ncv_pkg::MAX_WIDTH))
        begin
            w_eff = ncv_pkg::WEFF_W'(ncv_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = ncv_pkg::WEFF_W'(width_reg);
        end
        h_eff = (height_reg == '0) ? ncv_pkg::ROW_W'(1) : height_reg;

        // channel map, missing channels read as zero
        for (int ch = 0; ch < ncv_pkg::CHANNELS; ch++)
        begin
            unique case (ch)
                0:       in_pix[ch] = pixel_ch0;
                1:       in_pix[ch] = pixel_ch1;
                2:       in_pix[ch] = pixel_ch2;
                default: in_pix[ch] = '0;
            endcase
        end
        out_ch0 = (ncv_pkg::CHANNELS > 0) ? res_pix[0] : '0;
        out_ch1 = (ncv_pkg::CHANNELS > 1) ? res_pix[1] : '0;
        out_ch2 = (ncv_pkg::CHANNELS > 2) ? res_pix[2] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ncv_pkg::WCFG_W'(1024);
            height_reg <= ncv_pkg::ROW_W'(1024);
            kernel_reg <= ncv_pkg::KCFG_W'(3);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                ncv_pkg::CFG_WIDTH:  width_reg  <= cfg_data[ncv_pkg::WCFG_W-1:0];
                ncv_pkg::CFG_HEIGHT: height_reg <= cfg_data[ncv_pkg::ROW_W-1:0];
                ncv_pkg::CFG_KERNEL: kernel_reg <= cfg_data[ncv_pkg::KCFG_W-1:0];
                default:             width_reg  <= width_reg;
            endcase
        end
    end

    // front end: line buffers, window, frame counters
    ncv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .op         (op),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .pixel      (in_pix),
        .k_eff      (k_eff),
        .w_eff      (w_eff),
        .h_eff      (h_eff),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_data     (q_din)
    );

    // two-entry queue decoupling window capture from the arithmetic
    ncv_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .stat  (q_stat)
    );

    // back end: coefficient store, norm sweep, multiply-accumulate, divider
    ncv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .k_eff      (k_eff),
        .norm_start (norm_start),
        .q_stat     (q_stat),
        .q_data     (q_dout),
        .q_pop      (q_pop),
        .out_pop    (pop),
        .out_empty  (empty),
        .out_pix    (res_pix),
        .out_eof    (end_of_frame),
        .out_err    (divide_error)
    );

`ifndef SYNTHESIS
    // queue never written while full
    a_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("queue overflow");

    // queue never read while empty
    a_q_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue underflow");

    // a zero norm forces all channels to zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && divide_error) |-> (out_ch0 == '0 && out_ch1 == '0 && out_ch2 == '0))
        else $error("divide error with nonzero result");
`endif

endmodule

/* rtl/ncv_fifo.sv */
module ncv_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ncv_pkg::entry_t    din,
    input  logic               pop,
    output ncv_pkg::entry_t    dout,
    output ncv_pkg::fifo_stat_t stat
);

    ncv_pkg::entry_t mem_reg [2];
    logic            wptr_reg, wptr_next;
    logic            rptr_reg, rptr_next;
    logic [1:0]      cnt_reg, cnt_next;

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
        stat.full  = (cnt_reg == 2'd2);
        stat.empty = (cnt_reg == 2'd0);
        dout = mem_reg[rptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= din;
        end
    end

endmodule

/* rtl/ncv_front.sv */
module ncv_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          op,
    input  logic [ncv_pkg::CIDX_W-1:0]    coef_index,
    input  logic [ncv_pkg::COEF_W-1:0]    coef_value,
    input  ncv_pkg::pixel_t               pixel,
    input  logic [ncv_pkg::KS_W-1:0]      k_eff,
    input  logic [ncv_pkg::WEFF_W-1:0]    w_eff,
    input  logic [ncv_pkg::ROW_W-1:0]     h_eff,
    input  ncv_pkg::fifo_stat_t           q_stat,
    output logic                          q_push,
    output ncv_pkg::entry_t               q_data
);

    ncv_pkg::front_state_t state_reg, state_next;
    logic [ncv_pkg::ROW_W-1:0] row_reg, row_next;
    logic [ncv_pkg::COL_W-1:0] col_reg, col_next;
    logic [ncv_pkg::COL_W-1:0] addr_reg;
    ncv_pkg::pixel_t           pix_reg;
    logic                      emit_reg, eof_reg;
    ncv_pkg::line_word_t       rd_reg;
    ncv_pkg::line_word_t       wr_word;
    ncv_pkg::window_t          win_reg;
    ncv_pkg::pixel_t           col_vec [ncv_pkg::MAX_KERNEL];
    ncv_pkg::line_word_t       mem [ncv_pkg::MAX_WIDTH];

    logic [ncv_pkg::COL_W-1:0] col;
    logic                      accept, take_pix;
    logic                      emit, eof;
    logic [ncv_pkg::KS_W-1:0]  km1;

    always_comb
    begin
        km1 = k_eff - 1'b1;
        col = (ncv_pkg::WEFF_W'(col_reg) < w_eff) ? col_reg
                                                  : ncv_pkg::COL_W'(w_eff - 1'b1);
        full     = (state_reg != ncv_pkg::F_IDLE) || q_stat.full;
        accept   = push && !full;
        take_pix = accept && (op == ncv_pkg::OP_PIXEL);
        emit = (row_reg >= ncv_pkg::ROW_W'(km1)) && (col >= ncv_pkg::COL_W'(km1));
        eof  = (row_reg == h_eff - 1'b1) && (ncv_pkg::WEFF_W'(col) == w_eff - 1'b1);

        // next column vector: new pixel on top, older rows from the lines
        col_vec[0] = pix_reg;
        for (int d = 1; d < ncv_pkg::MAX_KERNEL; d++)
        begin
            col_vec[d] = rd_reg[d-1];
        end
        wr_word[0] = pix_reg;
        for (int d = 1; d < ncv_pkg::MAX_KERNEL - 1; d++)
        begin
            wr_word[d] = rd_reg[d-1];
        end

        row_next = row_reg;
        col_next = col_reg;
        if (take_pix)
        begin
            if (ncv_pkg::WEFF_W'(col) + 1'b1 >= w_eff)
            begin
                col_next = '0;
                row_next = ({1'b0, row_reg} + 1'b1 >= {1'b0, h_eff}) ? '0
                                                                      : row_reg + 1'b1;
            end
            else
            begin
                col_next = col + 1'b1;
            end
        end

        q_push          = 1'b0;
        q_data.is_coef    = 1'b0;
        q_data.coef_index = coef_index;
        q_data.coef_value = coef_value;
        q_data.win        = win_reg;
        q_data.eof        = eof_reg;
        state_next = state_reg;
        unique case (state_reg)
            ncv_pkg::F_IDLE:
            begin
                if (accept && (op == ncv_pkg::OP_LOAD))
                begin
                    q_push         = 1'b1;
                    q_data.is_coef = 1'b1;
                end
                if (take_pix)
                begin
                    state_next = ncv_pkg::F_SHIFT;
                end
            end
            ncv_pkg::F_SHIFT:
            begin
                state_next = emit_reg ? ncv_pkg::F_PUSH : ncv_pkg::F_IDLE;
            end
            ncv_pkg::F_PUSH:
            begin
                if (!q_stat.full)
                begin
                    q_push     = 1'b1;
                    state_next = ncv_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = ncv_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ncv_pkg::F_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            emit_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            if (take_pix)
            begin
                emit_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_pix)
        begin
            addr_reg <= col;
            pix_reg  <= pixel;
            eof_reg  <= eof;
            rd_reg   <= mem[col];
        end
        if (state_reg == ncv_pkg::F_SHIFT)
        begin
            mem[addr_reg] <= wr_word;
            for (int a = ncv_pkg::MAX_KERNEL - 1; a > 0; a--)
            begin
                win_reg[a] <= win_reg[a-1];
            end
            for (int d = 0; d < ncv_pkg::MAX_KERNEL; d++)
            begin
                win_reg[0][d] <= col_vec[d];
            end
        end
    end

endmodule

/* rtl/ncv_back.sv */
module ncv_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ncv_pkg::KS_W-1:0]    k_eff,
    input  logic                        norm_start,
    input  ncv_pkg::fifo_stat_t         q_stat,
    input  ncv_pkg::entry_t             q_data,
    output logic                        q_pop,
    input  logic                        out_pop,
    output logic                        out_empty,
    output ncv_pkg::pixel_t             out_pix,
    output logic                        out_eof,
    output logic                        out_err
);

    ncv_pkg::back_state_t state_reg, state_next;
    logic [ncv_pkg::COEF_W-1:0] coef_reg [ncv_pkg::NTAPS];
    logic [ncv_pkg::NORM_W-1:0] norm_reg;
    logic [ncv_pkg::NORM_W-1:0] sum_reg;
    logic [ncv_pkg::TAP_W-1:0]  idx_reg;
    logic                       pend_reg;
    logic [ncv_pkg::KS_W-1:0]   kr_reg, kc_reg;
    logic [ncv_pkg::TAP_W-1:0]  ci_reg;
    logic [ncv_pkg::PROD_W-1:0] prod_reg [ncv_pkg::CHANNELS];
    logic                       prod_v_reg;
    logic [ncv_pkg::ACC_W-1:0]  acc_reg [ncv_pkg::CHANNELS];
    logic [ncv_pkg::NORM_W-1:0] rem_reg [ncv_pkg::CHANNELS];
    logic [ncv_pkg::DCNT_W-1:0] cnt_reg;
    logic                       eof_reg, err_reg;
    logic                       out_v_reg;
    ncv_pkg::pixel_t            out_pix_reg;
    logic                       out_eof_reg, out_err_reg;

    logic [ncv_pkg::TAP_W-1:0]  kk;
    logic [ncv_pkg::KS_W-1:0]   wa, wd;
    logic                       load_out;
    logic [ncv_pkg::NORM_W:0]   shifted [ncv_pkg::CHANNELS];

    always_comb
    begin
        kk = ncv_pkg::TAP_W'(k_eff) * ncv_pkg::TAP_W'(k_eff);
        wa = k_eff - 1'b1 - kc_reg;
        wd = k_eff - 1'b1 - kr_reg;
        for (int ch = 0; ch < ncv_pkg::CHANNELS; ch++)
        begin
            shifted[ch] = {rem_reg[ch], acc_reg[ch][ncv_pkg::ACC_W-1]};
        end
        q_pop      = 1'b0;
        load_out   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ncv_pkg::B_IDLE:
            begin
                if (pend_reg)
                begin
                    state_next = ncv_pkg::B_NORM;
                end
                else if (!q_stat.empty)
                begin
                    if (q_data.is_coef)
                    begin
                        q_pop = 1'b1;
                        if (ncv_pkg::TAP_W'(q_data.coef_index) < ncv_pkg::TAP_W'(ncv_pkg::NTAPS))
                        begin
                            state_next = ncv_pkg::B_NORM;
                        end
                    end
                    else if (norm_reg == '0)
                    begin
                        q_pop      = 1'b1;
                        state_next = ncv_pkg::B_OUT;
                    end
                    else
                    begin
                        state_next = ncv_pkg::B_MUL;
                    end
                end
            end
            ncv_pkg::B_NORM:
            begin
                if (idx_reg >= kk)
                begin
                    state_next = ncv_pkg::B_IDLE;
                end
            end
            ncv_pkg::B_MUL:
            begin
                if (kr_reg >= k_eff)
                begin
                    q_pop      = 1'b1;
                    state_next = ncv_pkg::B_DIV;
                end
            end
            ncv_pkg::B_DIV:
            begin
                if (cnt_reg == ncv_pkg::DCNT_W'(ncv_pkg::ACC_W - 1))
                begin
                    state_next = ncv_pkg::B_OUT;
                end
            end
            ncv_pkg::B_OUT:
            begin
                if (!out_v_reg || out_pop)
                begin
                    load_out   = 1'b1;
                    state_next = ncv_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = ncv_pkg::B_IDLE;
            end
        endcase
        out_empty = !out_v_reg;
        out_pix   = out_pix_reg;
        out_eof   = out_eof_reg;
        out_err   = out_err_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ncv_pkg::B_IDLE;
            norm_reg  <= '0;
            pend_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            for (int i = 0; i < ncv_pkg::NTAPS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (norm_start)
            begin
                pend_reg <= 1'b1;
            end
            else if (state_reg == ncv_pkg::B_IDLE && pend_reg)
            begin
                pend_reg <= 1'b0;
            end
            if (state_reg == ncv_pkg::B_IDLE && !pend_reg && q_pop && q_data.is_coef
                && state_next == ncv_pkg::B_NORM)
            begin
                coef_reg[q_data.coef_index] <= q_data.coef_value;
            end
            if (state_reg == ncv_pkg::B_NORM && idx_reg >= kk)
            begin
                norm_reg <= sum_reg;
            end
            if (load_out)
            begin
                out_v_reg <= 1'b1;
            end
            else if (out_pop)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ncv_pkg::B_IDLE:
            begin
                sum_reg    <= '0;
                idx_reg    <= '0;
                kr_reg     <= '0;
                kc_reg     <= '0;
                ci_reg     <= '0;
                prod_v_reg <= 1'b0;
                cnt_reg    <= '0;
                eof_reg    <= q_data.eof;
                err_reg    <= (norm_reg == '0);
                for (int ch = 0; ch < ncv_pkg::CHANNELS; ch++)
                begin
                    acc_reg[ch] <= '0;
                    rem_reg[ch] <= '0;
                end
            end
            ncv_pkg::B_NORM:
            begin
                if (idx_reg < kk)
                begin
                    sum_reg <= sum_reg + ncv_pkg::NORM_W'(coef_reg[idx_reg]);
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            ncv_pkg::B_MUL:
            begin
                // multiply one tap, add the previous product
                for (int ch = 0; ch < ncv_pkg::CHANNELS; ch++)
                begin
                    if (prod_v_reg)
                    begin
                        acc_reg[ch] <= acc_reg[ch] + ncv_pkg::ACC_W'(prod_reg[ch]);
                    end
                    prod_reg[ch] <= q_data.win[wa][wd][ch] * coef_reg[ci_reg];
                end
                prod_v_reg <= (kr_reg < k_eff);
                if (kr_reg < k_eff)
                begin
                    ci_reg <= ci_reg + 1'b1;
                    if (kc_reg == k_eff - 1'b1)
                    begin
                        kc_reg <= '0;
                        kr_reg <= kr_reg + 1'b1;
                    end
                    else
                    begin
                        kc_reg <= kc_reg + 1'b1;
                    end
                end
            end
            ncv_pkg::B_DIV:
            begin
                // restoring division, one quotient bit per cycle
                cnt_reg <= cnt_reg + 1'b1;
                for (int ch = 0; ch < ncv_pkg::CHANNELS; ch++)
                begin
                    if (shifted[ch] >= {1'b0, norm_reg})
                    begin
                        rem_reg[ch] <= ncv_pkg::NORM_W'(shifted[ch] - {1'b0, norm_reg});
                        acc_reg[ch] <= {acc_reg[ch][ncv_pkg::ACC_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[ch] <= shifted[ch][ncv_pkg::NORM_W-1:0];
                        acc_reg[ch] <= {acc_reg[ch][ncv_pkg::ACC_W-2:0], 1'b0};
                    end
                end
            end
            ncv_pkg::B_OUT:
            begin
                if (load_out)
                begin
                    for (int ch = 0; ch < ncv_pkg::CHANNELS; ch++)
                    begin
                        out_pix_reg[ch] <= err_reg ? '0 : acc_reg[ch][ncv_pkg::PIX_W-1:0];
                    end
                    out_eof_reg <= eof_reg;
                    out_err_reg <= err_reg;
                end
            end
            default:
            begin
                cnt_reg <= '0;
            end
        endcase
    end

endmodule
